// ----- sv/hrfp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrfp_pkg
// Shared types, constants and helper functions for the HTTP response
// framing parser.
// ----------------------------------------------------------------------------
package hrfp_pkg;

    // Width of the body and chunk byte counters.
    localparam int COUNT_WIDTH = 32;
    // Width of a parsed decimal or hex value: capped at 32 bits.
    localparam int VAL_BITS    = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
    // Product width before the overflow check (value times 16 plus digit).
    localparam int PROD_BITS   = VAL_BITS + 4;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int CL_LEN = 14;
    localparam int TE_LEN = 17;
    localparam int CK_LEN = 7;
    localparam logic [8*CL_LEN-1:0] CL_NAME = "Content-Length";
    localparam logic [8*TE_LEN-1:0] TE_NAME = "Transfer-Encoding";
    localparam logic [8*CK_LEN-1:0] CK_WORD = "chunked";

    // Parser phase, one-hot.
    typedef enum logic [6:0] {
        PH_STATUS  = 7'b0000001,
        PH_HEADERS = 7'b0000010,
        PH_BODY    = 7'b0000100,
        PH_CSIZE   = 7'b0001000,
        PH_CDATA   = 7'b0010000,
        PH_CTAIL   = 7'b0100000,
        PH_LTAIL   = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        EV_FRAMING  = 2'd0,
        EV_PAYLOAD  = 2'd1,
        EV_COMPLETE = 2'd2,
        EV_ERROR    = 2'd3
    } t_event;

    // Position within a header line: name, separator skip, value.
    typedef enum logic [1:0] {
        VP_NAME  = 2'd0,
        VP_SKIP  = 2'd1,
        VP_VALUE = 2'd2
    } t_value_phase;

    // Candidate header names.
    localparam int CAND_CL = 0;
    localparam int CAND_TE = 1;

    function automatic logic [7:0] cl_char(logic [4:0] pos);
        if (pos < 5'(CL_LEN)) begin
            return CL_NAME[8*(CL_LEN-1-int'(pos)) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] te_char(logic [4:0] pos);
        if (pos < 5'(TE_LEN)) begin
            return TE_NAME[8*(TE_LEN-1-int'(pos)) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic logic [7:0] ck_char(logic [3:0] pos);
        if (pos < 4'(CK_LEN)) begin
            return CK_WORD[8*(CK_LEN-1-int'(pos)) +: 8];
        end
        return 8'h00;
    endfunction

    // Returns {valid, digit}; hex selects base 16.
    function automatic logic [4:0] digit_decode(logic [7:0] c, logic hex);
        logic [7:0] t;
        t = 8'h00;
        if (c >= "0" && c <= "9") begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end
        if (hex && c >= "a" && c <= "f") begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end
        if (hex && c >= "A" && c <= "F") begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

// ----- sv/http_response_framing_parser_top.sv -----
// ----------------------------------------------------------------------------
// http_response_framing_parser_top
// Byte-wide HTTP/1.1 response framing parser: classifies each byte of a
// response stream as framing, payload, message/chunk completion or error.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_data_byte. A byte transfers on a
//   rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall with o_event_res and o_payload. One
//   result per input byte, in order.
//   Output: each result is registered and appears in the cycle after its byte transfers.
//   Throughput: one byte per cycle while o_stall is low; all parser state is updated in the same
//   cycle the byte transfers, and the result lands in an output register.
//   Stall: while the result register is full and i_stall is high, o_stall is
//   high and the result holds. When the receiver takes the result, a new
//   byte may transfer in the same cycle.
//   Reset: synchronous, active low. Clears the result register and returns
//   the parser to the status line with no length or chunked mode.
//   Errors: the offending byte gives an error event, and the parser drops
//   all message state and expects a new status line.
// ----------------------------------------------------------------------------
module http_response_framing_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_event_res,
    output logic [7:0] o_payload
);
    import hrfp_pkg::*;

    // Parser state
    t_phase                 r_phase, n_phase;
    logic                   r_cr_seen, n_cr_seen;
    logic [1:0]             r_space_cnt, n_space_cnt;
    logic                   r_line_empty, n_line_empty;
    logic [4:0]             r_name_pos, n_name_pos;
    logic [1:0]             r_name_cand, n_name_cand;
    t_value_phase           r_value_phase, n_value_phase;
    logic [VAL_BITS-1:0]    r_value_acc, n_value_acc;
    logic                   r_value_has_digit, n_value_has_digit;
    logic                   r_value_bad, n_value_bad;
    logic [3:0]             r_word_pos, n_word_pos;
    logic                   r_chunked, n_chunked;
    logic [COUNT_WIDTH-1:0] r_body_len, n_body_len;
    logic [COUNT_WIDTH-1:0] r_bytes_rem, n_bytes_rem;

    // Result register
    logic                   r_valid;
    t_event                 r_event, n_event;
    logic [7:0]             r_payload, n_payload;

    logic                   w_in_xfer;
    logic                   w_err;
    logic                   w_clr_line;
    logic                   w_clr_msg;
    logic [4:0]             w_digit;
    logic [PROD_BITS-1:0]   w_acc_ext;
    logic [PROD_BITS-1:0]   w_acc_next;
    logic                   w_acc_ovf;
    logic [COUNT_WIDTH-1:0] w_rem_dec;
    logic [COUNT_WIDTH-1:0] w_acc_cnt;
    logic [7:0]             c;

    assign c         = i_data_byte;
    assign o_stall   = r_valid && i_stall;
    assign w_in_xfer = i_valid && !o_stall;

    // Digit accumulation: hex in chunk size lines, decimal in header values.
    assign w_digit    = digit_decode(c, r_phase == PH_CSIZE);
    assign w_acc_ext  = PROD_BITS'(r_value_acc);
    assign w_acc_next = ((r_phase == PH_CSIZE) ? (w_acc_ext << 4)
                                               : ((w_acc_ext << 3) + (w_acc_ext << 1)))
                        + PROD_BITS'(w_digit[3:0]);
    assign w_acc_ovf  = (w_acc_next[PROD_BITS-1:VAL_BITS] != '0);
    assign w_acc_cnt  = COUNT_WIDTH'(r_value_acc);
    assign w_rem_dec  = (r_bytes_rem != '0) ? (r_bytes_rem - 1'b1) : '0;

    always_comb begin
        n_phase           = r_phase;
        n_cr_seen         = r_cr_seen;
        n_space_cnt       = r_space_cnt;
        n_line_empty      = r_line_empty;
        n_name_pos        = r_name_pos;
        n_name_cand       = r_name_cand;
        n_value_phase     = r_value_phase;
        n_value_acc       = r_value_acc;
        n_value_has_digit = r_value_has_digit;
        n_value_bad       = r_value_bad;
        n_word_pos        = r_word_pos;
        n_chunked         = r_chunked;
        n_body_len        = r_body_len;
        n_bytes_rem       = r_bytes_rem;
        n_event           = EV_FRAMING;
        n_payload         = 8'h00;
        w_err             = 1'b0;
        w_clr_line        = 1'b0;
        w_clr_msg         = 1'b0;

        if (r_phase == PH_BODY || r_phase == PH_CDATA) begin
            n_payload   = c;
            n_bytes_rem = w_rem_dec;
            if (r_phase == PH_BODY) begin
                if (w_rem_dec == '0) begin
                    n_event   = EV_COMPLETE;
                    w_clr_msg = 1'b1;
                end else begin
                    n_event = EV_PAYLOAD;
                end
            end else begin
                n_event = EV_PAYLOAD;
                if (w_rem_dec == '0) begin
                    n_phase    = PH_CTAIL;
                    w_clr_line = 1'b1;
                end
            end
        end else if (r_cr_seen) begin
            if (c != CH_LF) begin
                w_err = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_STATUS: begin
                        if (r_space_cnt >= 2'd2) begin
                            n_phase    = PH_HEADERS;
                            w_clr_line = 1'b1;
                        end else begin
                            w_err = 1'b1;
                        end
                    end
                    PH_HEADERS: begin
                        if (r_line_empty) begin
                            w_clr_line = 1'b1;
                            if (r_body_len != '0) begin
                                n_bytes_rem = r_body_len;
                                n_phase     = PH_BODY;
                            end else if (r_chunked) begin
                                n_phase = PH_CSIZE;
                            end else begin
                                n_event   = EV_COMPLETE;
                                w_clr_msg = 1'b1;
                            end
                        end else if (r_value_phase == VP_NAME) begin
                            // line without a colon: ignore it
                            w_clr_line = 1'b1;
                        end else if (r_name_cand[CAND_CL]) begin
                            if (!r_value_has_digit || r_value_bad) begin
                                w_err = 1'b1;
                            end else begin
                                n_body_len = w_acc_cnt;
                                w_clr_line = 1'b1;
                            end
                        end else begin
                            if (r_name_cand[CAND_TE] && !r_value_bad
                                && r_word_pos == 4'(CK_LEN)) begin
                                n_chunked = 1'b1;
                            end
                            w_clr_line = 1'b1;
                        end
                    end
                    PH_CSIZE: begin
                        if (!r_value_has_digit || r_value_bad) begin
                            w_err = 1'b1;
                        end else begin
                            w_clr_line = 1'b1;
                            if (w_acc_cnt == '0) begin
                                n_phase = PH_LTAIL;
                            end else begin
                                n_bytes_rem = w_acc_cnt;
                                n_phase     = PH_CDATA;
                            end
                        end
                    end
                    PH_CTAIL: begin
                        n_event    = EV_COMPLETE;
                        n_phase    = PH_CSIZE;
                        w_clr_line = 1'b1;
                    end
                    PH_LTAIL: begin
                        n_event   = EV_COMPLETE;
                        w_clr_msg = 1'b1;
                    end
                    default: begin
                        w_err = 1'b1;
                    end
                endcase
            end
        end else if (c == CH_CR) begin
            n_cr_seen = 1'b1;
        end else begin
            n_line_empty = 1'b0;
            unique case (r_phase)
                PH_STATUS: begin
                    if (c == CH_SPACE && r_space_cnt < 2'd2) begin
                        n_space_cnt = r_space_cnt + 2'd1;
                    end
                end
                PH_HEADERS: begin
                    if (r_value_phase == VP_NAME) begin
                        if (c == CH_COLON) begin
                            if (r_name_pos != 5'(CL_LEN)) n_name_cand[CAND_CL] = 1'b0;
                            if (r_name_pos != 5'(TE_LEN)) n_name_cand[CAND_TE] = 1'b0;
                            n_value_phase = VP_SKIP;
                        end else begin
                            if (r_name_pos >= 5'(CL_LEN) || c != cl_char(r_name_pos)) begin
                                n_name_cand[CAND_CL] = 1'b0;
                            end
                            if (r_name_pos >= 5'(TE_LEN) || c != te_char(r_name_pos)) begin
                                n_name_cand[CAND_TE] = 1'b0;
                            end
                            if (r_name_pos != 5'd31) n_name_pos = r_name_pos + 5'd1;
                        end
                    end else if (r_value_phase == VP_SKIP) begin
                        n_value_phase = VP_VALUE;
                    end else begin
                        if (r_name_cand[CAND_CL]) begin
                            if (!w_digit[4]) begin
                                n_value_bad = 1'b1;
                            end else begin
                                n_value_has_digit = 1'b1;
                                if (!r_value_bad) begin
                                    if (w_acc_ovf) n_value_bad = 1'b1;
                                    else n_value_acc = w_acc_next[VAL_BITS-1:0];
                                end
                            end
                        end
                        if (r_name_cand[CAND_TE]) begin
                            if (r_word_pos >= 4'(CK_LEN) || c != ck_char(r_word_pos)) begin
                                n_value_bad = 1'b1;
                            end
                            if (r_word_pos != 4'd15) n_word_pos = r_word_pos + 4'd1;
                        end
                    end
                end
                PH_CSIZE: begin
                    if (!w_digit[4]) begin
                        n_value_bad = 1'b1;
                    end else begin
                        n_value_has_digit = 1'b1;
                        if (!r_value_bad) begin
                            if (w_acc_ovf) n_value_bad = 1'b1;
                            else n_value_acc = w_acc_next[VAL_BITS-1:0];
                        end
                    end
                end
                default: begin
                    // chunk tails accept only CR LF
                    w_err = 1'b1;
                end
            endcase
        end

        if (w_err) begin
            n_event   = EV_ERROR;
            n_payload = 8'h00;
            w_clr_msg = 1'b1;
        end

        if (w_clr_line || w_clr_msg) begin
            n_cr_seen         = 1'b0;
            n_space_cnt       = 2'd0;
            n_line_empty      = 1'b1;
            n_name_pos        = 5'd0;
            n_name_cand       = 2'b11;
            n_value_phase     = VP_NAME;
            n_value_acc       = '0;
            n_value_has_digit = 1'b0;
            n_value_bad       = 1'b0;
            n_word_pos        = 4'd0;
        end
        if (w_clr_msg) begin
            n_phase     = PH_STATUS;
            n_chunked   = 1'b0;
            n_body_len  = '0;
            n_bytes_rem = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_STATUS;
            r_cr_seen         <= 1'b0;
            r_space_cnt       <= 2'd0;
            r_line_empty      <= 1'b1;
            r_name_pos        <= 5'd0;
            r_name_cand       <= 2'b11;
            r_value_phase     <= VP_NAME;
            r_value_acc       <= '0;
            r_value_has_digit <= 1'b0;
            r_value_bad       <= 1'b0;
            r_word_pos        <= 4'd0;
            r_chunked         <= 1'b0;
            r_body_len        <= '0;
            r_bytes_rem       <= '0;
        end else if (w_in_xfer) begin
            r_phase           <= n_phase;
            r_cr_seen         <= n_cr_seen;
            r_space_cnt       <= n_space_cnt;
            r_line_empty      <= n_line_empty;
            r_name_pos        <= n_name_pos;
            r_name_cand       <= n_name_cand;
            r_value_phase     <= n_value_phase;
            r_value_acc       <= n_value_acc;
            r_value_has_digit <= n_value_has_digit;
            r_value_bad       <= n_value_bad;
            r_word_pos        <= n_word_pos;
            r_chunked         <= n_chunked;
            r_body_len        <= n_body_len;
            r_bytes_rem       <= n_bytes_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload: hold while stalled
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_event   <= n_event;
            r_payload <= n_payload;
        end
    end

    assign o_valid     = r_valid;
    assign o_event_res = r_event;
    assign o_payload   = r_payload;

    // A transferred byte always yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_valid)
        else $error("no result after input transfer");

    // Counted and chunk data phases never sit with nothing left to count.
    a_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY || r_phase == PH_CDATA) |-> (r_bytes_rem != '0))
        else $error("data phase with zero bytes remaining");

    // An error drops the parser back to the status line with modes cleared.
    a_error_recovers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_err) |=>
            (r_phase == PH_STATUS && !r_chunked && r_body_len == '0
             && r_event == EV_ERROR))
        else $error("error did not clear message state");

endmodule
